@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the two-formant vowel synthesiser.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge while reset is low.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// The condition must never be seen at a rising edge while reset is low.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ src/tfvs_pkg.sv @@
// Package of the two-formant vowel synthesiser: widths, types, the cosine table
// and the sequencer microprogram. Depends on nothing.
package tfvs_pkg;

  // Sizing of the cosine table and of the resonator history.
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int HISTORY_WIDTH   = 32;

  localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH);
  localparam int COS_W     = 18;
  localparam int COEF_W    = 18;
  localparam int MUL_A_W   = HISTORY_WIDTH + 1;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = HISTORY_WIDTH + 3;
  localparam int SAMPLE_W  = 24;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 24;

  localparam int PROG_LEN = 10;
  localparam int STEP_W   = $clog2(PROG_LEN);

  localparam logic [15:0] RADIUS_RESET = 16'd64388;
  localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
  localparam longint unsigned COS_DEPTH_U = COS_TABLE_DEPTH;
  localparam longint SUM_CLAMP = 64'sd4398046511104;
  localparam int PULSE_VALUE = 65536;
  localparam int SAMPLE_MAX  = 8388607;
  localparam int SAMPLE_MIN  = -8388608;

  typedef logic signed [HISTORY_WIDTH-1:0] hist_t;
  typedef logic signed [COS_W-1:0]         cos_t;
  typedef logic signed [COEF_W-1:0]        coef_t;
  typedef logic signed [MUL_A_W-1:0]       mul_a_t;
  typedef logic signed [MUL_B_W-1:0]       mul_b_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [ACC_W-1:0]         acc_t;
  typedef logic signed [SAMPLE_W-1:0]      sample_t;
  typedef logic [COS_IDX_W-1:0]            cos_idx_t;
  typedef logic [STEP_W-1:0]               step_t;
  typedef cos_t cos_tab_t [COS_TABLE_DEPTH];

  localparam hist_t HIST_MAX = {1'b0, {(HISTORY_WIDTH-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HISTORY_WIDTH-1){1'b0}}};
  localparam step_t LAST_STEP = STEP_W'(PROG_LEN - 1);

  // Sequencer state.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MA_RADIUS,
    MA_Y1_NEW,
    MA_Y1_OLD,
    MA_Y2_NEW,
    MA_Y2_OLD,
    MA_SUM
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_COS,
    MB_RADIUS,
    MB_A1,
    MB_A2,
    MB_B,
    MB_LEVEL
  } mul_b_sel_t;

  // Where the product of the previous step is written back.
  typedef enum logic [2:0] {
    WB_NONE,
    WB_A1,
    WB_A2,
    WB_B,
    WB_ACC,
    WB_RES1,
    WB_RES2,
    WB_OUT
  } wb_sel_t;

  // One control word of the microprogram.
  typedef struct packed {
    mul_a_sel_t a_sel;
    mul_b_sel_t b_sel;
    logic       mul_en;
    wb_sel_t    wb;
    logic       cos_load;
    logic       wait_out;
    logic       done;
  } ucode_t;

  // Unsigned quotient by restoring shift-and-subtract, used only for the table build.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One cosine entry in Q1.16, from a Taylor series in Q28 over the folded angle.
  function automatic cos_t cos_entry(input int k);
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint sum;
    longint q;
    m = longint'(k);
    if (m > COS_DEPTH_U - m) m = COS_DEPTH_U - m;
    x = (m * TWO_PI_Q28 + COS_DEPTH_U / 2) >> COS_IDX_W;
    x2 = (x * x + (64'd1 << 27)) >> 28;
    term = 64'd1 << 28;
    sum = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      div = longint'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 28, div);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    q = (sum + 2048) >>> 12;
    if (q > 65536) q = 65536;
    if (q < -65536) q = -65536;
    return cos_t'(q);
  endfunction

  // The whole table over one turn, worked out at elaboration.
  function automatic cos_tab_t cos_tab_build();
    cos_tab_t tab;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      tab[k] = cos_entry(k);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = cos_tab_build();

  // Table index of a formant step: (step * depth) >> 16, truncated.
  function automatic cos_idx_t cos_index(input logic [14:0] stp);
    logic [31:0] wide;
    wide = 32'(stp) * 32'(COS_TABLE_DEPTH);
    return wide[16 +: COS_IDX_W];
  endfunction

  // The microprogram: a step issues at most one multiply and one write-back.
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    w = '{a_sel: MA_RADIUS, b_sel: MB_COS, mul_en: 1'b0, wb: WB_NONE,
          cos_load: 1'b0, wait_out: 1'b0, done: 1'b0};
    case (int'(s))
      0: begin
        w.a_sel = MA_RADIUS; w.b_sel = MB_COS; w.mul_en = 1'b1; w.cos_load = 1'b1;
      end
      1: begin
        w.a_sel = MA_RADIUS; w.b_sel = MB_COS; w.mul_en = 1'b1; w.wb = WB_A1;
      end
      2: begin
        w.a_sel = MA_RADIUS; w.b_sel = MB_RADIUS; w.mul_en = 1'b1; w.wb = WB_A2;
      end
      3: begin
        w.a_sel = MA_Y1_NEW; w.b_sel = MB_A1; w.mul_en = 1'b1; w.wb = WB_B;
      end
      4: begin
        w.a_sel = MA_Y1_OLD; w.b_sel = MB_B; w.mul_en = 1'b1; w.wb = WB_ACC;
      end
      5: begin
        w.a_sel = MA_Y2_NEW; w.b_sel = MB_A2; w.mul_en = 1'b1; w.wb = WB_RES1;
      end
      6: begin
        w.a_sel = MA_Y2_OLD; w.b_sel = MB_B; w.mul_en = 1'b1; w.wb = WB_ACC;
      end
      7: begin
        w.wb = WB_RES2;
      end
      8: begin
        w.a_sel = MA_SUM; w.b_sel = MB_LEVEL; w.mul_en = 1'b1;
      end
      9: begin
        w.wb = WB_OUT; w.wait_out = 1'b1; w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/two_formant_vowel_synth_unit.sv @@
// Top level of the two-formant vowel synthesiser: microcoded sequencer around
// one shared multiplier. Depends on tfvs_pkg and assert_macros.svh.
//
//   channel   | direction | handshake                 | contents
//   ----------+-----------+---------------------------+----------------------------------
//   s_axis    | in        | tvalid/tready             | one sample tick, tlast = block end
//   m_axis    | out       | tvalid/tready             | one synthesised sample, tlast
//   cfg       | in        | cfg_we, no back-pressure  | pole radius, Q0.16
//
// A word is accepted and then runs a ten-step program that
// issues eight multiplies through the single shared multiplier.
// Reset clears the phase, the resonator histories and the output valid, returns the
// sequencer to idle and sets the pole radius to RADIUS_RESET; there is no clearing pass.
// The result sits in an output register, so the sequencer returns to idle and
// takes the next word while a result waits; it holds at its last step only if
// the previous result has still not been taken.
`include "assert_macros.svh"

module two_formant_vowel_synth_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pitch_step [15:0], formant_one_step [30:16], formant_two_step [45:31],
  // level [61:46], zero fill [63:62]
  input  logic [tfvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sample [23:0]
  output logic [tfvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  tfvs_pkg::seq_state_t state, state_next;
  tfvs_pkg::step_t      step, step_next;
  tfvs_pkg::ucode_t     uc;

  logic [15:0] pole_radius;
  logic [15:0] glottal_phase;
  logic        pulse;
  logic [14:0] f2_step;
  logic [15:0] level;
  logic        last_in_block;

  tfvs_pkg::hist_t  y1_new, y1_old, y2_new, y2_old;
  tfvs_pkg::cos_t   cos_q;
  tfvs_pkg::coef_t  coef_a1, coef_a2, coef_b;
  tfvs_pkg::acc_t   acc;
  tfvs_pkg::prod_t  prod;

  logic [15:0] in_pitch;
  logic [14:0] in_f1;
  logic [14:0] in_f2;
  logic [15:0] in_level;
  logic        in_accept;
  logic        run;
  logic        hold;
  logic        fire;
  logic [16:0] phase_sum;

  tfvs_pkg::cos_idx_t cos_idx;
  tfvs_pkg::mul_a_t   mul_a;
  tfvs_pkg::mul_b_t   mul_b;
  tfvs_pkg::mul_a_t   sum_raw;
  tfvs_pkg::mul_a_t   sum_clamped;
  tfvs_pkg::prod_t    prod_r16;
  tfvs_pkg::prod_t    prod_r15;
  tfvs_pkg::prod_t    prod_r10;
  tfvs_pkg::acc_t     res_sum;
  tfvs_pkg::hist_t    res_sat;
  tfvs_pkg::acc_t     acc_start;
  tfvs_pkg::sample_t  sample_sat;

  // Unpack the input word.
  assign in_pitch  = s_axis_tdata[15:0];
  assign in_f1     = s_axis_tdata[30:16];
  assign in_f2     = s_axis_tdata[45:31];
  assign in_level  = s_axis_tdata[61:46];

  // Handshake and sequencer control.
  assign s_axis_tready = (state == tfvs_pkg::SEQ_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign uc            = tfvs_pkg::ucode(step);
  assign run           = (state == tfvs_pkg::SEQ_RUN);
  assign hold          = uc.wait_out && m_axis_tvalid && !m_axis_tready;
  assign fire          = run && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfvs_pkg::SEQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      tfvs_pkg::SEQ_IDLE: begin
        if (in_accept) begin
          state_next = tfvs_pkg::SEQ_RUN;
          step_next  = '0;
        end
      end
      tfvs_pkg::SEQ_RUN: begin
        if (!hold) begin
          if (uc.done) begin
            state_next = tfvs_pkg::SEQ_IDLE;
          end else begin
            step_next = tfvs_pkg::step_t'(step + 1'b1);
          end
        end
      end
      default: begin
        state_next = tfvs_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Pole radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_radius <= tfvs_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      pole_radius <= cfg_wdata;
    end
  end

  // Glottal phase accumulator; the carry out is the pulse for this sample.
  assign phase_sum = {1'b0, glottal_phase} + {1'b0, in_pitch};

  always_ff @(posedge clk) begin
    if (rst) begin
      glottal_phase <= '0;
    end else if (in_accept) begin
      glottal_phase <= phase_sum[15:0];
    end
  end

  // Capture the rest of the word for the program.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pulse         <= phase_sum[16];
      f2_step       <= in_f2;
      level         <= in_level;
      last_in_block <= s_axis_tlast;
    end
  end

  // Cosine lookup: the first formant while idle, the second on request.
  assign cos_idx = run ? tfvs_pkg::cos_index(f2_step) : tfvs_pkg::cos_index(in_f1);

  always_ff @(posedge clk) begin
    if (!run || uc.cos_load) begin
      cos_q <= tfvs_pkg::COS_TAB[cos_idx];
    end
  end

  // Sum of the two new resonator outputs, clamped to plus or minus SUM_CLAMP.
  assign sum_raw = tfvs_pkg::mul_a_t'(y1_new) + tfvs_pkg::mul_a_t'(y2_new);

  always_comb begin
    if (64'(sum_raw) > tfvs_pkg::SUM_CLAMP) begin
      sum_clamped = tfvs_pkg::mul_a_t'(tfvs_pkg::SUM_CLAMP);
    end else if (64'(sum_raw) < -tfvs_pkg::SUM_CLAMP) begin
      sum_clamped = tfvs_pkg::mul_a_t'(-tfvs_pkg::SUM_CLAMP);
    end else begin
      sum_clamped = sum_raw;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (uc.a_sel)
      tfvs_pkg::MA_RADIUS: mul_a = tfvs_pkg::mul_a_t'({1'b0, pole_radius});
      tfvs_pkg::MA_Y1_NEW: mul_a = tfvs_pkg::mul_a_t'(y1_new);
      tfvs_pkg::MA_Y1_OLD: mul_a = tfvs_pkg::mul_a_t'(y1_old);
      tfvs_pkg::MA_Y2_NEW: mul_a = tfvs_pkg::mul_a_t'(y2_new);
      tfvs_pkg::MA_Y2_OLD: mul_a = tfvs_pkg::mul_a_t'(y2_old);
      tfvs_pkg::MA_SUM:    mul_a = sum_clamped;
      default:             mul_a = '0;
    endcase
  end

  always_comb begin
    case (uc.b_sel)
      tfvs_pkg::MB_COS:    mul_b = tfvs_pkg::mul_b_t'(cos_q);
      tfvs_pkg::MB_RADIUS: mul_b = tfvs_pkg::mul_b_t'({2'b00, pole_radius});
      tfvs_pkg::MB_A1:     mul_b = tfvs_pkg::mul_b_t'(coef_a1);
      tfvs_pkg::MB_A2:     mul_b = tfvs_pkg::mul_b_t'(coef_a2);
      tfvs_pkg::MB_B:      mul_b = tfvs_pkg::mul_b_t'(coef_b);
      tfvs_pkg::MB_LEVEL:  mul_b = tfvs_pkg::mul_b_t'({2'b00, level});
      default:             mul_b = '0;
    endcase
  end

  // The multiplier, registered.
  always_ff @(posedge clk) begin
    if (fire && uc.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Rounding of the registered product for each kind of write-back.
  assign prod_r16 = (prod + tfvs_pkg::prod_t'(32768)) >>> 16;
  assign prod_r15 = (prod + tfvs_pkg::prod_t'(16384)) >>> 15;
  assign prod_r10 = (prod + tfvs_pkg::prod_t'(512)) >>> 10;

  assign acc_start = tfvs_pkg::acc_t'(prod_r16)
                   + (pulse ? tfvs_pkg::acc_t'(tfvs_pkg::PULSE_VALUE) : '0);
  assign res_sum   = acc + tfvs_pkg::acc_t'(prod_r16);

  // New resonator output, saturated to the history width.
  always_comb begin
    if (res_sum > tfvs_pkg::acc_t'(tfvs_pkg::HIST_MAX)) begin
      res_sat = tfvs_pkg::HIST_MAX;
    end else if (res_sum < tfvs_pkg::acc_t'(tfvs_pkg::HIST_MIN)) begin
      res_sat = tfvs_pkg::HIST_MIN;
    end else begin
      res_sat = tfvs_pkg::hist_t'(res_sum);
    end
  end

  // Output sample, saturated to 24 bits.
  always_comb begin
    if (prod_r10 > tfvs_pkg::prod_t'(tfvs_pkg::SAMPLE_MAX)) begin
      sample_sat = tfvs_pkg::sample_t'(tfvs_pkg::SAMPLE_MAX);
    end else if (prod_r10 < tfvs_pkg::prod_t'(tfvs_pkg::SAMPLE_MIN)) begin
      sample_sat = tfvs_pkg::sample_t'(tfvs_pkg::SAMPLE_MIN);
    end else begin
      sample_sat = tfvs_pkg::sample_t'(prod_r10);
    end
  end

  // Coefficient and accumulator write-back.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (uc.wb)
        tfvs_pkg::WB_A1:  coef_a1 <= tfvs_pkg::coef_t'(prod_r15);
        tfvs_pkg::WB_A2:  coef_a2 <= tfvs_pkg::coef_t'(prod_r15);
        tfvs_pkg::WB_B:   coef_b  <= tfvs_pkg::coef_t'(-prod_r16);
        tfvs_pkg::WB_ACC: acc     <= acc_start;
        default: begin
        end
      endcase
    end
  end

  // Resonator histories; the newest value is shifted in at the end of each sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      y1_new <= '0;
      y1_old <= '0;
      y2_new <= '0;
      y2_old <= '0;
    end else if (fire) begin
      case (uc.wb)
        tfvs_pkg::WB_RES1: begin
          y1_old <= y1_new;
          y1_new <= res_sat;
        end
        tfvs_pkg::WB_RES2: begin
          y2_old <= y2_new;
          y2_new <= res_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && uc.wb == tfvs_pkg::WB_OUT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && uc.wb == tfvs_pkg::WB_OUT) begin
      m_axis_tdata <= sample_sat;
      m_axis_tlast <= last_in_block;
    end
  end

  // Sequencer checks.
  `ASSERT_HOLDS(a_accept_starts_program, clk, rst, (s_axis_tvalid && s_axis_tready) |=> (state == tfvs_pkg::SEQ_RUN && step == '0), "accepted word did not start the program at its first step")
  `ASSERT_HOLDS(a_result_from_last_step, clk, rst, (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(state == tfvs_pkg::SEQ_RUN && step == tfvs_pkg::LAST_STEP), "result appeared outside the last program step")
  `ASSERT_HOLDS(a_stall_holds_step, clk, rst, (state == tfvs_pkg::SEQ_RUN && step == tfvs_pkg::LAST_STEP && m_axis_tvalid && !m_axis_tready) |=> (state == tfvs_pkg::SEQ_RUN && step == tfvs_pkg::LAST_STEP), "sequencer left its last step while the result register was full")
  `ASSERT_NEVER(a_step_in_program, clk, rst, state == tfvs_pkg::SEQ_RUN && step > tfvs_pkg::LAST_STEP, "step counter ran past the end of the program")

endmodule

@@ tb/sv/two_formant_vowel_synth_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of two_formant_vowel_synth_unit: a bit-exact model of the
// glottal pulse train and the two resonators predicts every output word.
// Depends on tfvs_pkg and on the unit itself.
module two_formant_vowel_synth_unit_tb;

  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint TIMEOUT_CYCLES = 600000;
  localparam longint unsigned Q28_TWO_PI = 64'd1686629713;
  localparam longint HIST_HI = (64'sd1 <<< (tfvs_pkg::HISTORY_WIDTH - 1)) - 1;
  localparam longint HIST_LO = -HIST_HI - 1;
  localparam longint SUM_LIMIT = 64'sd1 <<< 42;
  localparam longint FULL_PULSE = 65536;
  localparam int PHASE_WRAP = 65536;

  // One input word and one output word, as the block sees them.
  typedef struct packed {
    logic [15:0] pitch;
    logic [14:0] f1;
    logic [14:0] f2;
    logic [15:0] level;
    logic        last;
  } tick_t;

  typedef struct packed {
    tfvs_pkg::sample_t sample;
    logic              block_end;
  } voice_t;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_COMB
  } ready_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [15:0]                     cfg_wdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // pitch_step [15:0], formant_one_step [30:16], formant_two_step [45:31],
  // level [61:46], zero fill [63:62]
  logic [tfvs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // sample [23:0]
  logic [tfvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  two_formant_vowel_synth_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  tick_t  pending_ticks [$];
  voice_t expected_voice [$];
  int     fail_count = 0;

  // Predictor state: cosine table, pole radius, glottal phase and resonator history.
  int          cos_q16 [tfvs_pkg::COS_TABLE_DEPTH];
  logic [15:0] pole_r;
  int          glottal_acc;
  longint      res_hist [2][2];

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Cosine of k/depth of a turn in Q1.16, by a Taylor series in Q28 over the folded angle.
  function automatic int taylor_cos(input int k);
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    longint q;
    m = longint'(k);
    if (m > longint'(tfvs_pkg::COS_TABLE_DEPTH) - m) begin
      m = longint'(tfvs_pkg::COS_TABLE_DEPTH) - m;
    end
    x = (m * Q28_TWO_PI + tfvs_pkg::COS_TABLE_DEPTH / 2) / tfvs_pkg::COS_TABLE_DEPTH;
    x2 = (x * x + (64'd1 << 27)) >> 28;
    term = 64'd1 << 28;
    acc = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    q = (acc + 2048) >>> 12;
    if (q > 65536) q = 65536;
    if (q < -65536) q = -65536;
    return int'(q);
  endfunction

  // One two-pole resonator step; which selects the first or second formant.
  function automatic longint run_resonator(input int which, input logic [14:0] stp,
                                           input longint pulse);
    int idx;
    longint r;
    longint a;
    longint b;
    longint v;
    idx = (int'(stp) * tfvs_pkg::COS_TABLE_DEPTH) >>> 16;
    if (idx >= tfvs_pkg::COS_TABLE_DEPTH) idx = tfvs_pkg::COS_TABLE_DEPTH - 1;
    r = longint'({48'd0, pole_r});
    a = (r * longint'(cos_q16[idx]) + 16384) >>> 15;
    b = -((r * r + 32768) >>> 16);
    v = pulse + ((a * res_hist[which][0] + 32768) >>> 16)
              + ((b * res_hist[which][1] + 32768) >>> 16);
    if (v > HIST_HI) v = HIST_HI;
    if (v < HIST_LO) v = HIST_LO;
    res_hist[which][1] = res_hist[which][0];
    res_hist[which][0] = v;
    return v;
  endfunction

  // Advances the glottal phase and both formants by one sample and scales the sum.
  function automatic voice_t synth_vowel_sample(input tick_t tk);
    voice_t out;
    longint pulse;
    longint s;
    longint p;
    pulse = 0;
    glottal_acc = glottal_acc + int'(tk.pitch);
    if (glottal_acc >= PHASE_WRAP) begin
      glottal_acc = glottal_acc - PHASE_WRAP;
      pulse = FULL_PULSE;
    end
    s = run_resonator(0, tk.f1, pulse);
    s = s + run_resonator(1, tk.f2, pulse);
    if (s > SUM_LIMIT) s = SUM_LIMIT;
    if (s < -SUM_LIMIT) s = -SUM_LIMIT;
    p = (s * longint'({48'd0, tk.level}) + 512) >>> 10;
    if (p > tfvs_pkg::SAMPLE_MAX) p = tfvs_pkg::SAMPLE_MAX;
    if (p < tfvs_pkg::SAMPLE_MIN) p = tfvs_pkg::SAMPLE_MIN;
    out.sample = tfvs_pkg::sample_t'(p);
    out.block_end = tk.last;
    return out;
  endfunction

  // Predictor: follows reset and register writes, and works out the sample of each
  // accepted input word.
  always @(posedge clk) begin
    if (rst) begin
      pole_r = tfvs_pkg::RADIUS_RESET;
      glottal_acc = 0;
      res_hist[0][0] = 0;
      res_hist[0][1] = 0;
      res_hist[1][0] = 0;
      res_hist[1][1] = 0;
    end else begin
      if (cfg_we) pole_r = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_voice.push_back(synth_vowel_sample('{pitch: s_axis_tdata[15:0],
                                                      f1: s_axis_tdata[30:16],
                                                      f2: s_axis_tdata[45:31],
                                                      level: s_axis_tdata[61:46],
                                                      last: s_axis_tlast}));
      end
    end
  end

  // Sender: offers pending words in bursts of random length with random gaps.
  tick_t drv_tick;
  int    burst_left = 8;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || pending_ticks.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        drv_tick = pending_ticks.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, drv_tick.level, drv_tick.f2, drv_tick.f1, drv_tick.pitch};
        s_axis_tlast <= drv_tick.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: stalls on a changing pattern, and twice holds off for a long stretch so
  // that the unit fills up and stalls its input.
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          comb_phase = 0;
  int          words_taken = 0;
  int          hold_left = 0;
  int          holds_taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) words_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holds_taken < 2 && words_taken >= (holds_taken == 0 ? 300 : 1100)) begin
        holds_taken++;
        hold_left = LONG_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        comb_phase++;
        case (ready_mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (comb_phase % 3 != 0);
        endcase
      end
    end
  end

  // Monitor: each output word is checked against the oldest expected sample.
  voice_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_voice.size() == 0) begin
        $error("unexpected word: sample %0d, block_end %0b", $signed(m_axis_tdata),
               m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_voice.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $error("sample: expected %0d, actual %0d", want.sample, $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tlast !== want.block_end) begin
          $error("block_end: expected %0b, actual %0b", want.block_end, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic add_tick(input int pitch, input int f1, input int f2, input int level,
                          input bit last);
    pending_ticks.push_back('{pitch: pitch[15:0], f1: f1[14:0], f2: f2[14:0],
                              level: level[15:0], last: last});
  endtask

  // Random traffic: mostly sustained vowels (fixed pitch and formants, closed by a
  // block end), mixed with words whose fields are random over their whole range.
  task automatic queue_random_ticks(input int count, input bit resonant);
    tick_t seg;
    int len;
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_tick($urandom_range(0, 65535), $urandom_range(0, 32767),
                 $urandom_range(0, 32767), $urandom_range(0, 65535),
                 1'($urandom_range(0, 1)));
        made++;
      end else begin
        if (resonant) seg.pitch = 16'($urandom_range(20000, 65535));
        else if ($urandom_range(0, 3) == 0) seg.pitch = 16'($urandom_range(0, 65535));
        else seg.pitch = 16'($urandom_range(80, 2000));
        seg.f1 = resonant ? 15'($urandom_range(0, 127)) : 15'($urandom_range(300, 6000));
        seg.f2 = 15'($urandom_range(0, 32767));
        seg.level = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 1023))
                                                : 16'($urandom_range(0, 65535));
        len = $urandom_range(4, 48);
        for (int i = 0; i < len; i++) begin
          add_tick(int'(seg.pitch), int'(seg.f1), int'(seg.f2), int'(seg.level),
                   i == len - 1);
          made++;
        end
      end
    end
  endtask

  // Waits until every word has been sent and every sample has come back, then lets
  // the sequencer settle.
  task automatic wait_until_idle();
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_voice.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pole_radius(input logic [15:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int k = 0; k < tfvs_pkg::COS_TABLE_DEPTH; k++) cos_q16[k] = taylor_cos(k);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset radius: silence, an exact phase wrap, field
    // extremes, positive and negative output saturation, then free decay.
    add_tick(0, 0, 0, 0, 1'b0);
    add_tick(32768, 0, 32767, 256, 1'b0);
    add_tick(32768, 0, 32767, 256, 1'b1);
    add_tick(65535, 32767, 0, 65535, 1'b0);
    add_tick(65535, 0, 0, 65535, 1'b0);
    add_tick(65535, 0, 0, 65535, 1'b1);
    for (int i = 0; i < 8; i++) add_tick(65535, 16383, 16383, 65535, i == 7);
    for (int i = 0; i < 6; i++) add_tick(0, 16383, 200, 65535, i == 5);
    add_tick(0, 32767, 32767, 0, 1'b0);
    add_tick(1, 1, 1, 1, 1'b1);
    wait_until_idle();

    // Zero radius: no feedback at all.
    set_pole_radius(16'h0000);
    queue_random_ticks(150, 1'b0);
    wait_until_idle();

    // Largest radius, first formant near zero: the histories run into saturation.
    set_pole_radius(16'hffff);
    queue_random_ticks(350, 1'b1);
    wait_until_idle();

    set_pole_radius(tfvs_pkg::RADIUS_RESET);
    queue_random_ticks(450, 1'b0);
    wait_until_idle();

    for (int ph = 0; ph < 4; ph++) begin
      set_pole_radius(ph % 2 == 0 ? 16'($urandom_range(50000, 65535))
                                  : 16'($urandom_range(0, 65535)));
      queue_random_ticks(200, 1'b0);
      wait_until_idle();
    end

    if (fail_count == 0 && expected_voice.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/tfvs_pkg.sv
src/two_formant_vowel_synth_unit.sv
tb/sv/two_formant_vowel_synth_unit_tb.sv
